// ===== design/rled_pkg.sv =====
package rled_pkg;

    localparam int unsigned VCN_W = 64;

    // end_status codes
    localparam logic [1:0] END_ZERO  = 2'd0;
    localparam logic [1:0] END_CLEAN = 2'd1;
    localparam logic [1:0] END_TRUNC = 2'd2;
    localparam logic [1:0] END_BAD   = 2'd3;

    typedef struct packed {
        logic                    extent_valid;
        logic [VCN_W-1:0]        extent_vcn;
        logic signed [VCN_W-1:0] extent_lcn;
        logic [VCN_W-1:0]        extent_clusters;
        logic                    is_sparse;
        logic                    list_end;
        logic [1:0]              end_status;
    } t_result;

endpackage

// ===== design/run_list_extent_decoder.sv =====
// Run list extent decoder: one run list byte per beat in, at most one extent or end beat out.
// A result goes to the output register, or to the skid entry when the output is stalled.
// Throughput: one byte per cycle unless stalled; clock set by byte merge plus one 64-bit add.
// Reset (i_rst_n low, synchronous): decoder returns to header phase with a fresh list,
// start_vcn clears to zero, and the output and skid registers empty.
module run_list_extent_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    // start_vcn register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rled_pkg::VCN_W-1:0]       i_start_vcn,
    // extent channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_extent_valid,
    output logic [rled_pkg::VCN_W-1:0]       o_extent_vcn,
    output logic signed [rled_pkg::VCN_W-1:0] o_extent_lcn,
    output logic [rled_pkg::VCN_W-1:0]       o_extent_clusters,
    output logic                             o_is_sparse,
    output logic                             o_list_end,
    output logic [1:0]                       o_end_status
);
    import rled_pkg::*;

    logic [VCN_W-1:0] r_start_vcn;
    logic             in_accept;
    logic             skid_full;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    // The config port never back-pressures; the register is sampled by the decoder
    // only on the header byte that opens a list.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vcn <= '0;
        end else if (i_cfg_valid) begin
            r_start_vcn <= i_start_vcn;
        end
    end

    // Stall only once the skid stage holds a beat, so a byte is still taken while
    // the output register waits on a stalled consumer.
    assign o_in_stall = skid_full;
    assign in_accept  = i_in_valid && !skid_full;

    // Parse the header, merge count and delta bytes, update the running vcn and lcn.
    rled_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_start_vcn (r_start_vcn),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register plus one skid entry between decoder and consumer.
    rled_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept && res_valid),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .i_stall (i_out_stall)
    );

    assign o_extent_valid    = out_res.extent_valid;
    assign o_extent_vcn      = out_res.extent_vcn;
    assign o_extent_lcn      = out_res.extent_lcn;
    assign o_extent_clusters = out_res.extent_clusters;
    assign o_is_sparse       = out_res.is_sparse;
    assign o_list_end        = out_res.list_end;
    assign o_end_status      = out_res.end_status;

endmodule

// ===== design/rled_decode.sv =====
module rled_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    input  logic [rled_pkg::VCN_W-1:0]    i_start_vcn,
    output logic                          o_res_valid,
    output rled_pkg::t_result             o_res
);
    import rled_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_len_left, n_len_left;
    logic [3:0]       r_dlt_left, n_dlt_left;
    logic [3:0]       r_dlt_width, n_dlt_width;
    logic [2:0]       r_pos, n_pos;
    logic [VCN_W-1:0] r_len_acc, n_len_acc;
    logic [VCN_W-1:0] r_dlt_acc, n_dlt_acc;
    logic [VCN_W-1:0] r_lcn, n_lcn;
    logic [VCN_W-1:0] r_vcn, n_vcn;
    logic             r_fresh, n_fresh;

    logic [VCN_W-1:0] byte_lane;
    logic [VCN_W-1:0] len_merged;
    logic [VCN_W-1:0] dlt_merged;
    logic [VCN_W-1:0] dlt_ext;
    logic [VCN_W-1:0] lcn_sum;
    logic [3:0]       hdr_lw;
    logic [3:0]       hdr_dw;
    logic [3:0]       len_dec;
    logic [3:0]       dlt_dec;

    // Drop the byte into its lane of the little-endian field.
    assign byte_lane  = {{(VCN_W-8){1'b0}}, i_data_byte} << {r_pos, 3'b000};
    assign len_merged = r_len_acc | byte_lane;
    assign dlt_merged = r_dlt_acc | byte_lane;
    assign hdr_lw     = i_data_byte[3:0];
    assign hdr_dw     = i_data_byte[7:4];
    assign len_dec    = r_len_left - 4'd1;
    assign dlt_dec    = r_dlt_left - 4'd1;

    always_comb begin
        dlt_ext = dlt_merged;
        for (int k = 1; k < 8; k++) begin
            if (r_dlt_width == 4'(k) && dlt_merged[8*k-1]) begin
                dlt_ext = dlt_merged | ({VCN_W{1'b1}} << (8*k));
            end
        end
    end

    assign lcn_sum = r_lcn + dlt_ext;

    always_comb begin
        n_phase     = r_phase;
        n_len_left  = r_len_left;
        n_dlt_left  = r_dlt_left;
        n_dlt_width = r_dlt_width;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_dlt_acc   = r_dlt_acc;
        n_lcn       = r_lcn;
        n_vcn       = r_vcn;
        n_fresh     = r_fresh;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_fresh) begin
                    n_vcn   = i_start_vcn;
                    n_lcn   = '0;
                    n_fresh = 1'b0;
                end
                if (i_data_byte == 8'd0 || hdr_lw == 4'd0 || hdr_lw > 4'd8 ||
                    hdr_dw > 4'd8 || i_last_byte) begin
                    o_res_valid   = 1'b1;
                    o_res.list_end = 1'b1;
                    if (i_data_byte == 8'd0) begin
                        o_res.end_status = END_ZERO;
                    end else if (hdr_lw == 4'd0 || hdr_lw > 4'd8 || hdr_dw > 4'd8) begin
                        o_res.end_status = END_BAD;
                    end else begin
                        o_res.end_status = END_TRUNC;
                    end
                    if (i_last_byte) begin
                        n_fresh = 1'b1;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                end else begin
                    n_len_left  = hdr_lw;
                    n_dlt_left  = hdr_dw;
                    n_dlt_width = hdr_dw;
                    n_pos       = '0;
                    n_len_acc   = '0;
                    n_dlt_acc   = '0;
                    n_phase     = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_len_acc  = len_merged;
                n_pos      = r_pos + 3'd1;
                n_len_left = len_dec;
                if (len_dec == 4'd0 && r_dlt_width == 4'd0) begin
                    // sparse extent: no delta bytes, lcn reads as all ones
                    o_res_valid           = 1'b1;
                    o_res.extent_valid    = 1'b1;
                    o_res.extent_vcn      = r_vcn;
                    o_res.extent_lcn      = '1;
                    o_res.extent_clusters = len_merged;
                    o_res.is_sparse       = 1'b1;
                    n_vcn                 = r_vcn + len_merged;
                    n_phase               = PH_HEADER;
                    if (i_last_byte) begin
                        o_res.list_end   = 1'b1;
                        o_res.end_status = END_CLEAN;
                        n_fresh          = 1'b1;
                    end
                end else begin
                    if (len_dec == 4'd0) begin
                        n_pos   = '0;
                        n_phase = PH_DELTA;
                    end
                    if (i_last_byte) begin
                        o_res_valid      = 1'b1;
                        o_res.list_end   = 1'b1;
                        o_res.end_status = END_TRUNC;
                        n_phase          = PH_HEADER;
                        n_fresh          = 1'b1;
                    end
                end
            end
            PH_DELTA: begin
                n_dlt_acc  = dlt_merged;
                n_pos      = r_pos + 3'd1;
                n_dlt_left = dlt_dec;
                if (dlt_dec == 4'd0) begin
                    n_dlt_acc             = dlt_ext;
                    n_lcn                 = lcn_sum;
                    o_res_valid           = 1'b1;
                    o_res.extent_valid    = 1'b1;
                    o_res.extent_vcn      = r_vcn;
                    o_res.extent_lcn      = lcn_sum;
                    o_res.extent_clusters = r_len_acc;
                    n_vcn                 = r_vcn + r_len_acc;
                    n_phase               = PH_HEADER;
                    if (i_last_byte) begin
                        o_res.list_end   = 1'b1;
                        o_res.end_status = END_CLEAN;
                        n_fresh          = 1'b1;
                    end
                end else if (i_last_byte) begin
                    o_res_valid      = 1'b1;
                    o_res.list_end   = 1'b1;
                    o_res.end_status = END_TRUNC;
                    n_phase          = PH_HEADER;
                    n_fresh          = 1'b1;
                end
            end
            default: begin
                // drain the rest of the buffer after an early end
                if (i_last_byte) begin
                    n_phase = PH_HEADER;
                    n_fresh = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_len_left  <= '0;
            r_dlt_left  <= '0;
            r_dlt_width <= '0;
            r_pos       <= '0;
            r_len_acc   <= '0;
            r_dlt_acc   <= '0;
            r_lcn       <= '0;
            r_vcn       <= '0;
            r_fresh     <= 1'b1;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_len_left  <= n_len_left;
            r_dlt_left  <= n_dlt_left;
            r_dlt_width <= n_dlt_width;
            r_pos       <= n_pos;
            r_len_acc   <= n_len_acc;
            r_dlt_acc   <= n_dlt_acc;
            r_lcn       <= n_lcn;
            r_vcn       <= n_vcn;
            r_fresh     <= n_fresh;
        end
    end

endmodule

// ===== design/rled_skid.sv =====
module rled_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rled_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output rled_pkg::t_result o_data,
    input  logic              i_stall
);
    import rled_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            // output slot free or taken this cycle: advance
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

endmodule
